FILE: hw/rtl/wavhp_pkg.sv
// Shared types, constants and codes for the WAV header parser.
package wavhp_pkg;

  localparam int unsigned DIV_W = 32;

  localparam logic [31:0] POS_MAX    = 32'hFFFF_FFFF;
  localparam logic [31:0] MIN_LENGTH = 32'd44;
  localparam logic [31:0] WALK_START = 32'd12;
  localparam logic [33:0] NEXT_RESET = 34'd12;
  localparam logic [31:0] MS_PER_S   = 32'd1000;
  localparam logic [31:0] ID_FMT     = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA    = 32'h6174_6164;
  localparam logic [15:0] FMT_PCM    = 16'd1;

  localparam logic [7:0] RIFF_WORD [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] WAVE_WORD [4] = '{8'h57, 8'h41, 8'h56, 8'h45};

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_OTHER = 2'd1,
    KIND_FMT   = 2'd2,
    KIND_DATA  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_MISSING = 3'd3,
    ST_NOT_PCM = 3'd4
  } status_t;

  typedef struct packed {
    logic byte_en;
    logic clear;
    logic mul_d;
    logic div_start;
    logic div_sel;
    logic mul_ms;
    logic dur_clr;
    logic dur_load;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic hdr_ok;
    logic d_zero;
    logic rate_zero;
    logic div_done;
  } sts_t;

endpackage

FILE: hw/rtl/wavhp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module wavhp_div #(
  parameter int unsigned W = wavhp_pkg::DIV_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  import wavhp_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    part;
  logic [W:0]    trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    part     = {rem_r, quo_r[W-1]};
    trial    = part - {1'b0, dvs_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = part[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/wavhp_dpath.sv
// Datapath: byte parser state, status, duration arithmetic and result registers.
module wavhp_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  wavhp_pkg::cmd_t    cmd,
  output wavhp_pkg::sts_t    sts,
  input  logic [7:0]         in_data_byte,
  output logic               out_header_ok,
  output logic [2:0]         out_status,
  output logic [15:0]        out_channel_count,
  output logic [31:0]        out_rate_hz,
  output logic [15:0]        out_sample_bits,
  output logic [31:0]        out_audio_offset,
  output logic [31:0]        out_audio_length,
  output logic [31:0]        out_duration_ms
);
  import wavhp_pkg::*;

  logic [31:0] pos_r, pos_nxt;
  logic        magic_r, magic_nxt;
  logic [33:0] nstart_r, nstart_nxt;
  logic [63:0] shift_r, shift_nxt;
  kind_t       kind_r, kind_nxt;
  logic [31:0] cstart_r, cstart_nxt;
  logic [63:0] fmt_r, fmt_nxt;
  logic [15:0] fcode_r, fcode_nxt;
  logic [31:0] fhs_r, fhs_nxt;
  logic        fseen_r, fseen_nxt;
  logic [31:0] dhs_r, dhs_nxt;
  logic [31:0] dsize_r, dsize_nxt;
  logic        dseen_r, dseen_nxt;

  logic [31:0] diff;
  logic [31:0] k;
  logic [31:0] sz;
  logic [7:0]  b;

  logic [31:0] prod_r;
  logic [31:0] prod2_r;
  logic [31:0] dur_r;
  logic [31:0] ms_prod;
  logic [28:0] d_val;
  status_t     st;

  logic [31:0] div_a;
  logic [31:0] div_b;
  logic        div_done;
  logic [31:0] div_q;

  assign b = in_data_byte;

  always_comb begin
    pos_nxt    = pos_r;
    magic_nxt  = magic_r;
    nstart_nxt = nstart_r;
    shift_nxt  = shift_r;
    kind_nxt   = kind_r;
    cstart_nxt = cstart_r;
    fmt_nxt    = fmt_r;
    fcode_nxt  = fcode_r;
    fhs_nxt    = fhs_r;
    fseen_nxt  = fseen_r;
    dhs_nxt    = dhs_r;
    dsize_nxt  = dsize_r;
    dseen_nxt  = dseen_r;
    diff       = '0;
    k          = '0;
    sz         = '0;
    if (cmd.clear) begin
      pos_nxt    = '0;
      magic_nxt  = 1'b1;
      nstart_nxt = NEXT_RESET;
      shift_nxt  = '0;
      kind_nxt   = KIND_NONE;
      cstart_nxt = '0;
      fmt_nxt    = '0;
      fcode_nxt  = '0;
      fhs_nxt    = '0;
      fseen_nxt  = 1'b0;
      dhs_nxt    = '0;
      dsize_nxt  = '0;
      dseen_nxt  = 1'b0;
    end else if (cmd.byte_en && pos_r != POS_MAX) begin
      pos_nxt = pos_r + 32'd1;
      if (pos_r < 32'd4 && b != RIFF_WORD[pos_r[1:0]]) magic_nxt = 1'b0;
      if (pos_r >= 32'd8 && pos_r < 32'd12 && b != WAVE_WORD[pos_r[1:0]]) magic_nxt = 1'b0;
      if (pos_r >= WALK_START) begin
        if (kind_r != KIND_NONE && {1'b0, pos_r} == {1'b0, cstart_r} + 33'd8) begin
          case (kind_r)
            KIND_FMT: begin
              fseen_nxt = 1'b1;
              fhs_nxt   = cstart_r;
              fmt_nxt   = '0;
              fcode_nxt = '0;
            end
            KIND_DATA: begin
              dseen_nxt = 1'b1;
              dhs_nxt   = cstart_r;
              dsize_nxt = shift_r[63:32];
            end
            default: ;
          endcase
          kind_nxt = KIND_NONE;
        end
        if ({2'b00, pos_r} == nstart_r) cstart_nxt = pos_r;
        diff = pos_r - cstart_nxt;
        if (diff < 32'd8) begin
          shift_nxt = {b, shift_r[63:8]};
          if (diff == 32'd7) begin
            sz = shift_nxt[63:32];
            if (shift_nxt[31:0] == ID_FMT) kind_nxt = KIND_FMT;
            else if (shift_nxt[31:0] == ID_DATA) kind_nxt = KIND_DATA;
            else kind_nxt = KIND_OTHER;
            nstart_nxt = {2'b00, cstart_nxt} + 34'd8 + {2'b00, sz} + {33'd0, sz[0]};
          end
        end
        if (fseen_nxt) begin
          k = pos_r - fhs_nxt;
          if (k inside {[8:23]}) begin
            case (k[4:0])
              5'd8:    fcode_nxt[7:0]   = b;
              5'd9:    fcode_nxt[15:8]  = b;
              5'd10:   fmt_nxt[7:0]     = b;
              5'd11:   fmt_nxt[15:8]    = b;
              5'd12:   fmt_nxt[23:16]   = b;
              5'd13:   fmt_nxt[31:24]   = b;
              5'd14:   fmt_nxt[39:32]   = b;
              5'd15:   fmt_nxt[47:40]   = b;
              5'd22:   fmt_nxt[55:48]   = b;
              5'd23:   fmt_nxt[63:56]   = b;
              default: ;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      magic_r  <= 1'b1;
      nstart_r <= NEXT_RESET;
      shift_r  <= '0;
      kind_r   <= KIND_NONE;
      cstart_r <= '0;
      fmt_r    <= '0;
      fcode_r  <= '0;
      fhs_r    <= '0;
      fseen_r  <= 1'b0;
      dhs_r    <= '0;
      dsize_r  <= '0;
      dseen_r  <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      magic_r  <= magic_nxt;
      nstart_r <= nstart_nxt;
      shift_r  <= shift_nxt;
      kind_r   <= kind_nxt;
      cstart_r <= cstart_nxt;
      fmt_r    <= fmt_nxt;
      fcode_r  <= fcode_nxt;
      fhs_r    <= fhs_nxt;
      fseen_r  <= fseen_nxt;
      dhs_r    <= dhs_nxt;
      dsize_r  <= dsize_nxt;
      dseen_r  <= dseen_nxt;
    end
  end

  // pos_r equals the file length, saturating at POS_MAX, once the last byte is in
  always_comb begin
    if (pos_r < MIN_LENGTH) st = ST_SHORT;
    else if (!magic_r) st = ST_MAGIC;
    else if (!fseen_r || !dseen_r) st = ST_MISSING;
    else if (fcode_r != FMT_PCM) st = ST_NOT_PCM;
    else st = ST_OK;
  end

  assign d_val   = prod_r[31:3];
  assign ms_prod = div_q * MS_PER_S;
  assign div_a   = cmd.div_sel ? prod2_r : dsize_r;
  assign div_b   = cmd.div_sel ? fmt_r[47:16] : {3'b000, d_val};

  wavhp_div #(
    .W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul_d) prod_r <= {16'd0, fmt_r[15:0]} * {16'd0, fmt_r[63:48]};
    if (cmd.mul_ms) prod2_r <= ms_prod;
    if (cmd.dur_clr) dur_r <= '0;
    else if (cmd.dur_load) dur_r <= div_q;
    if (cmd.load_out) begin
      out_header_ok     <= (st == ST_OK);
      out_status        <= st;
      out_channel_count <= (st == ST_OK) ? fmt_r[15:0] : 16'd0;
      out_rate_hz       <= (st == ST_OK) ? fmt_r[47:16] : 32'd0;
      out_sample_bits   <= (st == ST_OK) ? fmt_r[63:48] : 16'd0;
      out_audio_offset  <= (st == ST_OK) ? dhs_r + 32'd8 : 32'd0;
      out_audio_length  <= (st == ST_OK) ? dsize_r : 32'd0;
      out_duration_ms   <= (st == ST_OK) ? dur_r : 32'd0;
    end
  end

  assign sts.hdr_ok    = (st == ST_OK);
  assign sts.d_zero    = (d_val == 29'd0);
  assign sts.rate_zero = (fmt_r[47:16] == 32'd0);
  assign sts.div_done  = div_done;

endmodule

FILE: hw/rtl/wavhp_ctrl.sv
// Controller: byte intake, end-of-file arithmetic sequence and result handshake.
module wavhp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_last_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output wavhp_pkg::cmd_t cmd,
  input  wavhp_pkg::sts_t sts
);
  import wavhp_pkg::*;

  typedef enum logic [2:0] {
    S_RUN,
    S_MULD,
    S_CHK,
    S_DIV1,
    S_MULMS,
    S_DIV2S,
    S_DIV2,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   sel_r, sel_nxt;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cmd           = '0;
    cmd.div_sel   = sel_r;
    in_ready      = 1'b0;
    case (state_r)
      S_RUN: begin
        in_ready    = 1'b1;
        cmd.byte_en = in_valid;
        if (in_valid && in_last_byte) state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd.mul_d = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!sts.hdr_ok || sts.d_zero || sts.rate_zero) begin
          cmd.dur_clr = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.div_sel   = 1'b0;
          cmd.div_start = 1'b1;
          sel_nxt       = 1'b0;
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts.div_done) state_nxt = S_MULMS;
      end
      S_MULMS: begin
        cmd.mul_ms = 1'b1;
        state_nxt  = S_DIV2S;
      end
      S_DIV2S: begin
        cmd.div_sel   = 1'b1;
        cmd.div_start = 1'b1;
        sel_nxt       = 1'b1;
        state_nxt     = S_DIV2;
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.dur_load = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/wav_header_chunk_parser.sv
// Top level of the WAV header parser: controller plus datapath.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | in_data_byte, in_last_byte
//   out_    | output    | out_valid / out_ready | header_ok, status, format, audio, duration
//
// Bytes are taken one per cycle while in_ready is high. After the last byte the block
// finds the bytes per frame, divides the data length by it, multiplies by 1000 and divides
// by the rate on the shared bit-serial divider; a bad header or zero divisor skips this.
// The result sits in an output register; the next file's bytes are taken while
// it waits, but after the next end of file in_ready stays low until it has gone out.
// Synchronous active-low reset returns the parser to the start of a file.
module wav_header_chunk_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_header_ok,
  output logic [2:0]  out_status,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_rate_hz,
  output logic [15:0] out_sample_bits,
  output logic [31:0] out_audio_offset,
  output logic [31:0] out_audio_length,
  output logic [31:0] out_duration_ms
);
  import wavhp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wavhp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  wavhp_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_data_byte      (in_data_byte),
    .out_header_ok     (out_header_ok),
    .out_status        (out_status),
    .out_channel_count (out_channel_count),
    .out_rate_hz       (out_rate_hz),
    .out_sample_bits   (out_sample_bits),
    .out_audio_offset  (out_audio_offset),
    .out_audio_length  (out_audio_length),
    .out_duration_ms   (out_duration_ms)
  );

endmodule

FILE: dv/wav_header_chunk_parser_test.sv
// Testbench for the WAV header parser: byte-stream files checked against an in-bench predictor.
module wav_header_chunk_parser_test;
  import wavhp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned CALM_FROM     = 1500;
  localparam int unsigned CALM_TO       = 2700;
  localparam logic [31:0] ID_LIST       = 32'h5453_494C;
  localparam logic [31:0] COMMON_RATES [7] = '{32'd8000, 32'd11025, 32'd16000, 32'd22050,
                                               32'd44100, 32'd48000, 32'd96000};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wav_byte_t;

  typedef struct packed {
    logic        ok;
    status_t     status;
    logic [15:0] ch;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] dur;
  } wav_info_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_header_ok;
  logic [2:0]  out_status;
  logic [15:0] out_channel_count;
  logic [31:0] out_rate_hz;
  logic [15:0] out_sample_bits;
  logic [31:0] out_audio_offset;
  logic [31:0] out_audio_length;
  logic [31:0] out_duration_ms;

  wav_byte_t   pending_bytes [$];
  wav_info_t   expected_headers [$];
  logic [7:0]  file_bytes [$];
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  logic        calm;

  // parser state mirror
  logic [31:0] pos_now;
  logic        magic_good;
  logic [33:0] next_start;
  logic [63:0] hdr_shift;
  kind_t       cur_kind;
  logic [31:0] cur_start;
  logic [63:0] fmt_fields;
  logic [31:0] fmt_start;
  logic        fmt_found;
  logic [31:0] data_start;
  logic [31:0] data_len;
  logic        data_found;
  logic [15:0] fmt_code;

  wav_header_chunk_parser u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_header_ok     (out_header_ok),
    .out_status        (out_status),
    .out_channel_count (out_channel_count),
    .out_rate_hz       (out_rate_hz),
    .out_sample_bits   (out_sample_bits),
    .out_audio_offset  (out_audio_offset),
    .out_audio_length  (out_audio_length),
    .out_duration_ms   (out_duration_ms)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  task automatic clear_wav_state();
    pos_now    = '0;
    magic_good = 1'b1;
    next_start = NEXT_RESET;
    hdr_shift  = '0;
    cur_kind   = KIND_NONE;
    cur_start  = '0;
    fmt_fields = '0;
    fmt_start  = '0;
    fmt_found  = 1'b0;
    data_start = '0;
    data_len   = '0;
    data_found = 1'b0;
    fmt_code   = '0;
  endtask

  task automatic parse_wav_byte(input logic [31:0] idx, input logic [7:0] b);
    logic [31:0] diff;
    logic [31:0] k;
    logic [31:0] id;
    logic [31:0] sz;
    if (idx < 4 && b != RIFF_WORD[idx[1:0]]) magic_good = 1'b0;
    if (idx >= 8 && idx < 12 && b != WAVE_WORD[idx[1:0]]) magic_good = 1'b0;
    if (idx < WALK_START) return;

    if (cur_kind != KIND_NONE && {2'b0, idx} == {2'b0, cur_start} + 34'd8) begin
      if (cur_kind == KIND_FMT) begin
        fmt_found  = 1'b1;
        fmt_start  = cur_start;
        fmt_fields = '0;
        fmt_code   = '0;
      end else if (cur_kind == KIND_DATA) begin
        data_found = 1'b1;
        data_start = cur_start;
        data_len   = hdr_shift[63:32];
      end
      cur_kind = KIND_NONE;
    end

    if ({2'b0, idx} == next_start) cur_start = idx;

    diff = idx - cur_start;
    if (diff < 8) begin
      hdr_shift = {b, hdr_shift[63:8]};
      if (diff == 7) begin
        id = hdr_shift[31:0];
        sz = hdr_shift[63:32];
        if (id == ID_FMT) cur_kind = KIND_FMT;
        else if (id == ID_DATA) cur_kind = KIND_DATA;
        else cur_kind = KIND_OTHER;
        next_start = {2'b0, cur_start} + 34'd8 + {2'b0, sz} + {33'b0, sz[0]};
      end
    end

    if (fmt_found) begin
      k = idx - fmt_start;
      if (k == 8) fmt_code[7:0] = b;
      else if (k == 9) fmt_code[15:8] = b;
      else if (k >= 10 && k <= 15) fmt_fields[8*(k-10) +: 8] = b;
      else if (k == 22 || k == 23) fmt_fields[48 + 8*(k-22) +: 8] = b;
    end
  endtask

  function automatic wav_info_t summarize_wav(input logic [31:0] flen);
    wav_info_t   info;
    status_t     st;
    logic [31:0] ch;
    logic [31:0] rate;
    logic [31:0] bits;
    logic [31:0] d;
    logic [31:0] samples;
    info = '0;
    if (flen < MIN_LENGTH) st = ST_SHORT;
    else if (!magic_good) st = ST_MAGIC;
    else if (!fmt_found || !data_found) st = ST_MISSING;
    else if (fmt_code != FMT_PCM) st = ST_NOT_PCM;
    else st = ST_OK;
    info.status = st;
    if (st == ST_OK) begin
      ch   = {16'b0, fmt_fields[15:0]};
      rate = fmt_fields[47:16];
      bits = {16'b0, fmt_fields[63:48]};
      d    = (ch * bits) >> 3;
      info.ok     = 1'b1;
      info.ch     = ch[15:0];
      info.rate   = rate;
      info.bits   = bits[15:0];
      info.offset = data_start + 32'd8;
      info.length = data_len;
      if (d != 0 && rate != 0) begin
        samples  = data_len / d;
        info.dur = (samples * MS_PER_S) / rate;
      end
    end
    return info;
  endfunction

  task automatic take_wav_byte(input logic [7:0] b, input logic last);
    logic [31:0] idx;
    logic [31:0] flen;
    idx = pos_now;
    if (idx != POS_MAX) begin
      parse_wav_byte(idx, b);
      pos_now = idx + 1;
      flen    = idx + 1;
    end else begin
      flen = POS_MAX;
    end
    if (last) begin
      expected_headers.push_back(summarize_wav(flen));
      clear_wav_state();
    end
  endtask

  // ----------------------------------------------------------------- checking
  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  task automatic check_header();
    wav_info_t want;
    if (expected_headers.size() == 0) begin
      $display("%0t: unexpected transaction, expected none actual status %0d",
               $time, out_status);
      err_cnt++;
    end else begin
      want = expected_headers.pop_front();
      check_field("header_ok", want.ok, out_header_ok);
      check_field("status", want.status, out_status);
      check_field("channel_count", want.ch, out_channel_count);
      check_field("rate_hz", want.rate, out_rate_hz);
      check_field("sample_bits", want.bits, out_sample_bits);
      check_field("audio_offset", want.offset, out_audio_offset);
      check_field("audio_length", want.length, out_audio_length);
      check_field("duration_ms", want.dur, out_duration_ms);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_header();
      if (in_valid && in_ready) take_wav_byte(in_data_byte, in_last_byte);
    end
  end

  // ------------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
          in_valid     <= 1'b1;
          in_data_byte <= pending_bytes[0].data;
          in_last_byte <= pending_bytes[0].last;
          void'(pending_bytes.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 34);
    end
  end

  // ----------------------------------------------------------- file building
  task automatic put_byte(input logic [7:0] b);
    file_bytes.push_back(b);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8]);
  endtask

  task automatic put_riff(input logic [31:0] riff_size);
    for (int i = 0; i < 4; i++) put_byte(RIFF_WORD[i]);
    put_word(riff_size);
    for (int i = 0; i < 4; i++) put_byte(WAVE_WORD[i]);
  endtask

  task automatic put_fmt(input logic [15:0] code, input logic [15:0] ch,
                         input logic [31:0] rate, input logic [15:0] bits,
                         input logic [31:0] size);
    logic [31:0]  byte_rate;
    logic [15:0]  align;
    logic [127:0] body;
    byte_rate = (rate * {16'b0, ch} * {16'b0, bits}) >> 3;
    align     = (ch * bits) >> 3;
    body      = {bits, align, byte_rate, rate, ch, code};
    put_word(ID_FMT);
    put_word(size);
    for (int unsigned i = 0; i < size; i++)
      put_byte(i < 16 ? body[8*i +: 8] : 8'($urandom_range(255)));
    if (size[0]) put_byte(8'h00);
  endtask

  task automatic put_chunk(input logic [31:0] id, input logic [31:0] size,
                           input int unsigned n_body);
    put_word(id);
    put_word(size);
    for (int unsigned i = 0; i < n_body; i++) put_byte(8'($urandom_range(255)));
    if (n_body == size && size[0]) put_byte(8'h00);
  endtask

  task automatic put_pcm_file(input logic [15:0] code, input logic [15:0] ch,
                              input logic [31:0] rate, input logic [15:0] bits,
                              input logic [31:0] size, input int unsigned n_body);
    put_riff(32'd36 + size);
    put_fmt(code, ch, rate, bits, 32'd16);
    put_chunk(ID_DATA, size, n_body);
  endtask

  task automatic cut_file(input int unsigned n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  task automatic ship_file();
    if (file_bytes.size() == 0) put_byte(8'($urandom_range(255)));
    for (int i = 0; i < file_bytes.size(); i++)
      pending_bytes.push_back('{data: file_bytes[i], last: (i == file_bytes.size() - 1)});
    file_bytes.delete();
  endtask

  task automatic random_fmt();
    logic [15:0] code;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [31:0] rate;
    logic [31:0] size;
    int unsigned r;
    code = ($urandom_range(99) < 88) ? FMT_PCM : 16'($urandom());
    ch   = ($urandom_range(99) < 75) ? 16'($urandom_range(1, 8)) : 16'($urandom());
    r    = $urandom_range(99);
    rate = (r < 60) ? COMMON_RATES[$urandom_range(6)] : (r < 70) ? 32'd0 : $urandom();
    bits = ($urandom_range(99) < 75) ? 16'(8 * $urandom_range(1, 4)) : 16'($urandom());
    r    = $urandom_range(99);
    size = (r < 70) ? 32'd16 : (r < 80) ? 32'd18 : 32'($urandom_range(0, 30));
    put_fmt(code, ch, rate, bits, size);
  endtask

  task automatic random_data();
    int unsigned n;
    n = $urandom_range(0, 24);
    if ($urandom_range(1)) put_chunk(ID_DATA, n, n);
    else put_chunk(ID_DATA, $urandom(), n);
  endtask

  task automatic random_other();
    int unsigned n;
    if ($urandom_range(99) < 6) begin
      put_chunk($urandom(), $urandom(), $urandom_range(0, 4));
    end else begin
      n = $urandom_range(0, 20);
      put_chunk($urandom(), n, n);
    end
  endtask

  task automatic random_file();
    int unsigned n;
    int unsigned i;
    if ($urandom_range(99) < 10) begin
      if ($urandom_range(1)) for (i = 0; i < 4; i++) put_byte(RIFF_WORD[i]);
      n = $urandom_range(1, 80);
      while (file_bytes.size() < n) put_byte(8'($urandom_range(255)));
    end else begin
      put_riff($urandom());
      if ($urandom_range(99) < 30) random_other();
      if ($urandom_range(99) < 88) random_fmt();
      if ($urandom_range(99) < 30) random_other();
      if ($urandom_range(99) < 88) random_data();
      if ($urandom_range(99) < 20) begin
        if ($urandom_range(1)) random_fmt();
        else random_data();
      end
      if ($urandom_range(99) < 15) random_other();
      if ($urandom_range(99) < 12) begin
        i = $urandom_range(file_bytes.size() - 1);
        file_bytes[i] ^= 8'($urandom_range(1, 255));
      end
      if ($urandom_range(99) < 10) cut_file($urandom_range(1, file_bytes.size()));
    end
    ship_file();
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    clear_wav_state();

    put_pcm_file(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'd8, 8);
    ship_file();
    put_byte(RIFF_WORD[0]);
    ship_file();
    put_pcm_file(FMT_PCM, 16'd1, 32'd8000, 16'd8, 32'd8, 8);
    cut_file(43);
    ship_file();
    put_pcm_file(FMT_PCM, 16'd1, 32'd8000, 16'd8, 32'd4, 4);
    file_bytes[0] = 8'h00;
    ship_file();
    put_pcm_file(FMT_PCM, 16'd1, 32'd8000, 16'd8, 32'd4, 4);
    file_bytes[11] ^= 8'h20;
    ship_file();
    // fmt without data, then data without fmt
    put_riff(32'd46);
    put_fmt(FMT_PCM, 16'd2, 32'd22050, 16'd16, 32'd16);
    put_chunk(ID_LIST, 32'd10, 10);
    ship_file();
    put_riff(32'd48);
    put_chunk(ID_DATA, 32'd40, 40);
    ship_file();
    put_pcm_file(16'd3, 16'd2, 32'd48000, 16'd32, 32'd16, 16);
    ship_file();
    // odd sizes get a pad byte
    put_riff(32'd60);
    put_chunk(ID_LIST, 32'd5, 5);
    put_fmt(FMT_PCM, 16'd1, 32'd22050, 16'd16, 32'd16);
    put_chunk(ID_DATA, 32'd7, 7);
    ship_file();
    // second fmt replaces the first
    put_riff(32'd80);
    put_fmt(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'd16);
    put_fmt(FMT_PCM, 16'd1, 32'd16000, 16'd24, 32'd18);
    put_chunk(ID_DATA, 32'd12, 12);
    ship_file();
    // fmt cut short: bits never seen
    put_riff(32'd60);
    put_chunk(ID_DATA, 32'd24, 24);
    put_fmt(FMT_PCM, 16'd2, 32'd48000, 16'd16, 32'd16);
    cut_file(60);
    ship_file();
    // chunk walk runs past the end
    put_riff($urandom());
    put_fmt(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'd16);
    put_chunk(ID_DATA, 32'hFFFF_FFFF, 10);
    ship_file();
    put_riff($urandom());
    put_chunk(ID_LIST, 32'hFFFF_FFFF, 0);
    put_fmt(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'd16);
    put_chunk(ID_DATA, 32'd8, 8);
    ship_file();
    put_pcm_file(FMT_PCM, 16'd2, 32'd0, 16'd16, 32'd100, 4);
    ship_file();
    put_pcm_file(FMT_PCM, 16'd1, 32'd1, 16'd8, 32'hFFFF_FFF0, 4);
    ship_file();
    put_pcm_file(FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 4);
    ship_file();
    // data header ends exactly at end of file, then one byte more
    put_riff(32'd36);
    put_fmt(FMT_PCM, 16'd1, 32'd8000, 16'd16, 32'd16);
    put_chunk(ID_DATA, 32'd0, 0);
    ship_file();
    put_riff(32'd37);
    put_fmt(FMT_PCM, 16'd1, 32'd8000, 16'd16, 32'd16);
    put_chunk(ID_DATA, 32'd0, 0);
    put_byte(8'hFF);
    ship_file();

    while (pending_bytes.size() < 1550) random_file();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_headers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
